// ----- rtl/q10_saturating_alu_with_sigmoid_assert.svh -----
// assertion macros for the q10 saturating alu
`ifndef Q10_SATURATING_ALU_WITH_SIGMOID_ASSERT_SVH
`define Q10_SATURATING_ALU_WITH_SIGMOID_ASSERT_SVH

// condition implies consequence in the same cycle
`define Q10_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define Q10_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/q10alu_pkg.sv -----
// shared types, constants and sigmoid threshold table for the q10 alu
package q10alu_pkg;

	localparam int FRAC_BITS = 10;
	localparam int DATA_W    = 16;
	localparam int MAG_W     = DATA_W + 1;
	localparam int SIG_IDX_W = FRAC_BITS - 1;
	localparam int SIG_N     = 1 << SIG_IDX_W;
	localparam int THR_W     = 16;
	localparam int SIG_W     = FRAC_BITS;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_MUL = 2'd1,
		CMD_SIG = 2'd2
	} cmd_t;

	typedef logic [THR_W-1:0] thr_tab_t [SIG_N];

	// entry i: smallest |a| at which the scaled sigmoid reaches SIG_N + 1 + i
	function automatic thr_tab_t build_thr();
		thr_tab_t tab;
		real      scale;
		real      t;
		int       k;
		scale = real'(1 << FRAC_BITS);
		for (int i = 0; i < SIG_N; i++) begin
			k = SIG_N + 1 + i;
			if (i == SIG_N - 1) begin
				tab[i] = '1;
			end else begin
				t = scale * ($ln(real'(k)) - $ln(real'((1 << FRAC_BITS) - k)));
				tab[i] = THR_W'(int'($ceil(t)));
			end
		end
		return tab;
	endfunction

	localparam thr_tab_t SIG_THR = build_thr();

endpackage

// ----- rtl/q10_saturating_alu_with_sigmoid.sv -----
// top level: four-stage q5.10 saturating add, rounded multiply and sigmoid
// an accepted input beat passes the stage registers s1, s2, s3 and s4 in order to become the result beat
// throughput: one beat per cycle, each stage holds under backpressure and bubbles collapse
// sigmoid is a 9-step threshold search split over three stages, add/mul over two
// reset: arst_n low clears all stage valid bits, no output beat until new input
`include "q10_saturating_alu_with_sigmoid_assert.svh"
module q10_saturating_alu_with_sigmoid
	import q10alu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // operand_a [15:0], operand_b [31:16]
	input  logic [1:0]  s_axis_tuser,  // cmd [1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // result_value [15:0]
	output logic [0:0]  m_axis_tuser   // overflow_flag [0]
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [DATA_W-1:0] operand_a;
	logic [DATA_W-1:0] operand_b;

	logic [MAG_W-1:0]     mag_s1, mag_s2, mag_s3;
	logic                 neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SIG_IDX_W-1:0] idx_s2, idx_s3, idx_s4;
	logic [MAG_W-1:0]     mag_s4;

	logic [DATA_W-1:0] arith_s2, arith_s3, arith_s4;
	logic              aovf_s2, aovf_s3, aovf_s4;
	logic [SIG_W-1:0]  sig_val;

	assign operand_a = s_axis_tdata[15:0];
	assign operand_b = s_axis_tdata[31:16];

	assign en_s4 = !v_s4 || m_axis_tready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1 <= cmd_t'(s_axis_tuser);
			neg_s1 <= operand_a[DATA_W-1];
			mag_s1 <= operand_a[DATA_W-1]
				? MAG_W'(-{operand_a[DATA_W-1], operand_a})
				: MAG_W'({1'b0, operand_a});
		end
		if (en_s2) cmd_s2 <= cmd_s1;
		if (en_s3) begin
			cmd_s3   <= cmd_s2;
			arith_s3 <= arith_s2;
			aovf_s3  <= aovf_s2;
		end
		if (en_s4) begin
			cmd_s4   <= cmd_s3;
			arith_s4 <= arith_s3;
			aovf_s4  <= aovf_s3;
		end
	end

	q10alu_arith u_arith (
		.clk         (clk),
		.en_s1       (en_s1),
		.en_s2       (en_s2),
		.cmd_s1      (cmd_s1),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.result_s2   (arith_s2),
		.overflow_s2 (aovf_s2)
	);

	q10alu_sig_stage #(.HI_BIT(8)) u_sig_s2 (
		.clk    (clk),
		.en     (en_s2),
		.mag_in (mag_s1),
		.neg_in (neg_s1),
		.idx_in ('0),
		.mag_q  (mag_s2),
		.neg_q  (neg_s2),
		.idx_q  (idx_s2)
	);

	q10alu_sig_stage #(.HI_BIT(5)) u_sig_s3 (
		.clk    (clk),
		.en     (en_s3),
		.mag_in (mag_s2),
		.neg_in (neg_s2),
		.idx_in (idx_s2),
		.mag_q  (mag_s3),
		.neg_q  (neg_s3),
		.idx_q  (idx_s3)
	);

	q10alu_sig_stage #(.HI_BIT(2)) u_sig_s4 (
		.clk    (clk),
		.en     (en_s4),
		.mag_in (mag_s3),
		.neg_in (neg_s3),
		.idx_in (idx_s3),
		.mag_q  (mag_s4),
		.neg_q  (neg_s4),
		.idx_q  (idx_s4)
	);

	// negative side mirrors: floor(1 - s) = max - floor(s) off the exact zero point
	assign sig_val = neg_s4 ? {1'b0, ~idx_s4} : {1'b1, idx_s4};

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tuser = '0;
		unique case (cmd_s4)
			CMD_ADD, CMD_MUL: begin
				m_axis_tdata = arith_s4;
				m_axis_tuser = aovf_s4;
			end
			CMD_SIG: begin
				m_axis_tdata = DATA_W'(sig_val);
				m_axis_tuser = 1'b0;
			end
			default: begin
				m_axis_tdata = '0;
				m_axis_tuser = '0;
			end
		endcase
	end

	assign m_axis_tvalid = v_s4;

	`Q10_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, v_s1,
		"accepted beat did not enter stage 1")
	`Q10_ASSERT_SAME(a_stall_only_when_full, !s_axis_tready, v_s1 && v_s2 && v_s3 && v_s4,
		"input stalled while a pipeline stage was empty")
	`Q10_ASSERT_SAME(a_sigmoid_range, m_axis_tvalid && cmd_s4 == CMD_SIG,
		m_axis_tuser == 1'b0 && m_axis_tdata[DATA_W-1:SIG_W] == '0,
		"sigmoid beat out of range or flagged overflow")
	`Q10_ASSERT_SAME(a_sigmoid_mag_side, v_s4 && cmd_s4 == CMD_SIG && !neg_s4,
		mag_s4[MAG_W-1] == 1'b0,
		"non-negative sigmoid operand with out-of-range magnitude")

endmodule

// ----- rtl/q10alu_arith.sv -----
// add and rounded multiply datapath, two stages, with clamping
module q10alu_arith
	import q10alu_pkg::*;
(
	input  logic              clk,
	input  logic              en_s1,
	input  logic              en_s2,
	input  cmd_t              cmd_s1,
	input  logic [DATA_W-1:0] operand_a,
	input  logic [DATA_W-1:0] operand_b,
	output logic [DATA_W-1:0] result_s2,
	output logic              overflow_s2
);

	localparam int RND_W = 2 * DATA_W - FRAC_BITS + 1;

	logic [DATA_W:0]     sum_s1;
	logic [2*DATA_W-1:0] prod_s1;
	logic [RND_W-1:0]    rnd;
	logic [DATA_W-1:0]   res_d;
	logic                ovf_d;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sum_s1  <= {operand_a[DATA_W-1], operand_a} + {operand_b[DATA_W-1], operand_b};
			prod_s1 <= (2*DATA_W)'($signed(operand_a) * $signed(operand_b));
		end
	end

	always_comb begin
		rnd = {prod_s1[2*DATA_W-1], prod_s1[2*DATA_W-1:FRAC_BITS]}
			+ RND_W'(prod_s1[FRAC_BITS-1]);
		res_d = '0;
		ovf_d = 1'b0;
		unique case (cmd_s1)
			CMD_ADD: begin
				ovf_d = sum_s1[DATA_W] != sum_s1[DATA_W-1];
				res_d = ovf_d ? {sum_s1[DATA_W], {(DATA_W-1){~sum_s1[DATA_W]}}}
					: sum_s1[DATA_W-1:0];
			end
			CMD_MUL: begin
				ovf_d = !((&rnd[RND_W-1:DATA_W-1]) || !(|rnd[RND_W-1:DATA_W-1]));
				res_d = ovf_d ? {rnd[RND_W-1], {(DATA_W-1){~rnd[RND_W-1]}}}
					: rnd[DATA_W-1:0];
			end
			default: begin
				res_d = '0;
				ovf_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			result_s2   <= res_d;
			overflow_s2 <= ovf_d;
		end
	end

endmodule

// ----- rtl/q10alu_sig_stage.sv -----
// one pipeline stage of the sigmoid threshold search, three index bits
module q10alu_sig_stage
	import q10alu_pkg::*;
#(
	parameter int HI_BIT = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [MAG_W-1:0]     mag_in,
	input  logic                 neg_in,
	input  logic [SIG_IDX_W-1:0] idx_in,
	output logic [MAG_W-1:0]     mag_q,
	output logic                 neg_q,
	output logic [SIG_IDX_W-1:0] idx_q
);

	localparam int STEPS = 3;

	logic [SIG_IDX_W-1:0] idx;
	logic [SIG_IDX_W-1:0] probe;

	always_comb begin
		idx   = idx_in;
		probe = '0;
		for (int j = 0; j < STEPS; j++) begin
			probe = idx | SIG_IDX_W'((1 << (HI_BIT - j)) - 1);
			if (MAG_W'(SIG_THR[probe]) <= mag_in) begin
				idx = idx | SIG_IDX_W'(1 << (HI_BIT - j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= mag_in;
			neg_q <= neg_in;
			idx_q <= idx;
		end
	end

endmodule

// ----- dv/testbench.sv -----
// testbench for the q5.10 saturating add, rounded multiply and sigmoid unit
`timescale 1ns / 1ps
module testbench;
	import q10alu_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int N_DIRECTED = 23;
	localparam int RANDOM_PER_PHASE = 120;
	localparam int N_PHASES = 4;

	typedef struct packed {
		logic signed [15:0] value;
		logic               ovf;
	} alu_result_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               typed;
		alu_result_t        want;
	} alu_op_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // operand_a [15:0], operand_b [31:16]
	logic [1:0]  s_axis_tuser = '0;  // cmd [1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // result_value [15:0]
	logic [0:0]  m_axis_tuser;       // overflow_flag [0]

	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;
	int          mismatch_count = 0;
	alu_op_t     alu_expected [$];
	alu_op_t     beat_want;

	int idle_tab [N_PHASES] = '{0, 57, 0, 25};
	int stall_tab [N_PHASES] = '{0, 0, 57, 25};

	alu_op_t directed_rows [N_DIRECTED] = '{
		'{CMD_ADD, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 1'b0}},
		'{CMD_ADD, 16'sd32767, 16'sd1, 1'b1, '{16'sd32767, 1'b1}},
		'{CMD_ADD, 16'sh8000, -16'sd1, 1'b1, '{16'sh8000, 1'b1}},
		'{CMD_ADD, 16'sd32767, 16'sh8000, 1'b1, '{-16'sd1, 1'b0}},
		'{CMD_ADD, 16'sh8000, 16'sh8000, 1'b1, '{16'sh8000, 1'b1}},
		'{CMD_ADD, 16'sd16384, 16'sd16383, 1'b1, '{16'sd32767, 1'b0}},
		'{CMD_MUL, 16'sd1024, 16'sd1024, 1'b1, '{16'sd1024, 1'b0}},
		'{CMD_MUL, 16'sh8000, 16'sh8000, 1'b1, '{16'sd32767, 1'b1}},
		'{CMD_MUL, 16'sd32767, 16'sh8000, 1'b1, '{16'sh8000, 1'b1}},
		'{CMD_MUL, 16'sd1, 16'sd512, 1'b1, '{16'sd1, 1'b0}},
		'{CMD_MUL, 16'sd1, 16'sd511, 1'b1, '{16'sd0, 1'b0}},
		'{CMD_MUL, -16'sd1, 16'sd512, 1'b0, '{16'sd0, 1'b0}},
		'{CMD_MUL, -16'sd1, 16'sd511, 1'b0, '{16'sd0, 1'b0}},
		'{CMD_MUL, 16'sd32767, 16'sd32767, 1'b1, '{16'sd32767, 1'b1}},
		'{CMD_MUL, 16'sd0, 16'sh8000, 1'b1, '{16'sd0, 1'b0}},
		'{CMD_SIG, 16'sd0, -16'sd1, 1'b1, '{16'sd512, 1'b0}},
		'{CMD_SIG, 16'sd32767, 16'sd32767, 1'b1, '{16'sd1023, 1'b0}},
		'{CMD_SIG, 16'sh8000, 16'sh8000, 1'b1, '{16'sd0, 1'b0}},
		'{CMD_SIG, 16'sd1024, 16'sd0, 1'b0, '{16'sd0, 1'b0}},
		'{CMD_SIG, -16'sd1024, 16'sd0, 1'b0, '{16'sd0, 1'b0}},
		'{CMD_SIG, -16'sd1, 16'sd0, 1'b0, '{16'sd0, 1'b0}},
		'{CMD_NONE, 16'sd32767, -16'sd1, 1'b1, '{16'sd0, 1'b0}},
		'{CMD_NONE, 16'sh8000, 16'sd0, 1'b1, '{16'sd0, 1'b0}}
	};

	q10_saturating_alu_with_sigmoid DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	function automatic alu_result_t clamp_q10(longint v);
		alu_result_t r;
		r.ovf = 1'b1;
		if (v > 32767) begin
			r.value = 16'sd32767;
		end else if (v < -32768) begin
			r.value = 16'sh8000;
		end else begin
			r.value = 16'(v);
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	function automatic alu_result_t alu_predict(logic [1:0] cmd, logic signed [15:0] a,
			logic signed [15:0] b);
		alu_result_t r;
		longint      prod;
		real         scale;
		real         level;
		r = '0;
		scale = real'(1 << FRAC_BITS);
		case (cmd)
			CMD_ADD: r = clamp_q10(longint'(a) + longint'(b));
			CMD_MUL: begin
				prod = longint'(a) * longint'(b);
				r = clamp_q10((prod >>> FRAC_BITS) + longint'(prod[FRAC_BITS-1]));
			end
			CMD_SIG: begin
				level = scale / (1.0 + $exp(-real'(a) / scale));
				r.value = 16'(int'($floor(level)));
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] pick_operand();
		logic signed [15:0] v;
		case ($urandom_range(3))
			0: v = 16'($urandom);
			1: v = 16'(int'($urandom_range(4095)) - 2048);
			2: begin
				case ($urandom_range(5))
					0: v = 16'sh8000;
					1: v = 16'sh8001;
					2: v = -16'sd1;
					3: v = 16'sd0;
					4: v = 16'sd1;
					default: v = 16'sd32767;
				endcase
			end
			default: v = 16'(int'($urandom_range(16383)) - 8192);
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("ERROR at %0t: %s", $realtime, what);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_op(input alu_op_t op);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= $urandom;
			@(negedge clk);
		end
		if (!op.typed)
			op.want = alu_predict(op.cmd, op.a, op.b);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {op.b, op.a};
		s_axis_tuser <= op.cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		alu_expected.push_back(op);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (alu_expected.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				beat_want = alu_expected.pop_front();
				if (m_axis_tdata !== beat_want.want.value)
					report_mismatch($sformatf("cmd %0d a %0d b %0d: value %0d, want %0d",
						beat_want.cmd, beat_want.a, beat_want.b,
						$signed(m_axis_tdata), beat_want.want.value));
				if (m_axis_tuser[0] !== beat_want.want.ovf)
					report_mismatch($sformatf("cmd %0d a %0d b %0d: overflow %b, want %b",
						beat_want.cmd, beat_want.a, beat_want.b,
						m_axis_tuser[0], beat_want.want.ovf));
			end
		end
	end

	initial begin
		alu_op_t op;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			send_op(directed_rows[i]);
		for (int ph = 0; ph < N_PHASES; ph++) begin
			sender_idle_pct = idle_tab[ph];
			receiver_stall_pct = stall_tab[ph];
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				op = '0;
				op.cmd = ($urandom_range(19) == 0) ? CMD_NONE : 2'($urandom_range(2));
				op.a = pick_operand();
				op.b = pick_operand();
				send_op(op);
			end
		end
		s_axis_tvalid <= 1'b0;
		receiver_stall_pct = 0;
		while (alu_expected.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/q10alu_pkg.sv
rtl/q10alu_arith.sv
rtl/q10alu_sig_stage.sv
rtl/q10_saturating_alu_with_sigmoid.sv
dv/testbench.sv
